[hw/rtl/rva_pkg.sv]
// ----------------------------------------------------------------------------
// rva_pkg
// Types, widths and helpers shared by the radial vignette alpha blocks.
// ----------------------------------------------------------------------------
package rva_pkg;

  localparam int unsigned MAX_FRAME_DIM  = 4096;
  localparam int unsigned DIST_FRAC_BITS = 8;

  localparam int unsigned DIM_W  = 13;
  localparam int unsigned PIX_W  = 12;
  localparam int unsigned OFF_W  = 13;
  localparam int unsigned SQ_W   = 2 * OFF_W + 2;               // even, holds dx^2 + dy^2
  localparam int unsigned V_W    = SQ_W + 2 * DIST_FRAC_BITS;
  localparam int unsigned ROOT_W = V_W / 2;
  localparam int unsigned REM_W  = ROOT_W + 4;
  localparam int unsigned M_W    = DIM_W + DIST_FRAC_BITS;
  localparam int unsigned D5_W   = ROOT_W + 3;
  localparam int unsigned NUM_W  = M_W + 8;
  localparam int unsigned Q_BITS = 8;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = FIFO_AW + 1;

  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;

  typedef enum logic [1:0] {
    CLS_ZERO,
    CLS_RAMP,
    CLS_FULL
  } cls_e;

  typedef struct packed {
    logic               empty;
    logic [FIFO_CW-1:0] count;
  } fifo_stat_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    r = d;
    if (d == '0) r = DIM_W'(1);
    else if (d > DIM_W'(MAX_FRAME_DIM)) r = DIM_W'(MAX_FRAME_DIM);
    return r;
  endfunction

endpackage

[hw/rtl/rva_front.sv]
// ----------------------------------------------------------------------------
// rva_front
// Accepts pixel requests, forms half-pixel offsets and the squared distance.
// ----------------------------------------------------------------------------
module rva_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        pixel_valid_i,
  output logic                        pixel_stall_o,
  input  logic [rva_pkg::PIX_W-1:0]   pixel_x_i,
  input  logic [rva_pkg::PIX_W-1:0]   pixel_y_i,
  input  logic [rva_pkg::DIM_W-1:0]   width_i,
  input  logic [rva_pkg::DIM_W-1:0]   height_i,
  input  rva_pkg::fifo_stat_t         fifo_stat_i,
  output logic                        push_o,
  output logic [rva_pkg::SQ_W-1:0]    push_sq_o
);
  import rva_pkg::*;

  logic             vld_q, vld_d;
  logic [OFF_W-1:0] adx_q, adx_d, ady_q, ady_d;
  logic [OFF_W-1:0] px2, py2;
  logic [2*OFF_W-1:0] sqx, sqy;
  logic             accept;

  // reserve a slot for the item already sitting in the offset stage
  assign pixel_stall_o = (FIFO_CW'(fifo_stat_i.count) + FIFO_CW'(vld_q)) >= FIFO_CW'(FIFO_DEPTH);
  assign accept        = pixel_valid_i && !pixel_stall_o;

  always_comb begin
    px2   = {pixel_x_i, 1'b0};
    py2   = {pixel_y_i, 1'b0};
    vld_d = accept;
    adx_d = (px2 >= width_i)  ? (px2 - width_i)  : (width_i - px2);
    ady_d = (py2 >= height_i) ? (py2 - height_i) : (height_i - py2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      adx_q <= adx_d;
      ady_q <= ady_d;
    end
  end

  assign sqx       = adx_q * adx_q;
  assign sqy       = ady_q * ady_q;
  assign push_o    = vld_q;
  assign push_sq_o = SQ_W'(sqx) + SQ_W'(sqy);

endmodule

[hw/rtl/rva_fifo.sv]
// ----------------------------------------------------------------------------
// rva_fifo
// Short queue of squared distances between front and back.
// ----------------------------------------------------------------------------
module rva_fifo (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  logic [rva_pkg::SQ_W-1:0]  push_sq_i,
  input  logic                      pop_i,
  output logic [rva_pkg::SQ_W-1:0]  pop_sq_o,
  output rva_pkg::fifo_stat_t       stat_o
);
  import rva_pkg::*;

  logic [SQ_W-1:0]    mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [FIFO_CW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_d  = push_i ? wr_q + FIFO_AW'(1) : wr_q;
    rd_d  = pop_i  ? rd_q + FIFO_AW'(1) : rd_q;
    cnt_d = cnt_q + FIFO_CW'(push_i) - FIFO_CW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_sq_i;
  end

  assign pop_sq_o     = mem_q[rd_q];
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.count = cnt_q;

endmodule

[hw/rtl/rva_back.sv]
// ----------------------------------------------------------------------------
// rva_back
// Pipelined square root, edge classification and ramp divide.
// ----------------------------------------------------------------------------
module rva_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rva_pkg::fifo_stat_t       fifo_stat_i,
  input  logic [rva_pkg::SQ_W-1:0]  pop_sq_i,
  output logic                      pop_o,
  input  logic [rva_pkg::DIM_W-1:0] width_i,
  input  logic [rva_pkg::DIM_W-1:0] height_i,
  output logic                      alpha_valid_o,
  input  logic                      alpha_stall_i,
  output logic [7:0]                alpha_o
);
  import rva_pkg::*;

  // root stages
  logic              s_vld_q  [ROOT_W+1];
  logic [V_W-1:0]    s_v_q    [ROOT_W+1];
  logic [REM_W-1:0]  s_rem_q  [ROOT_W+1];
  logic [ROOT_W-1:0] s_root_q [ROOT_W+1];
  logic [V_W-1:0]    s_v_d    [ROOT_W+1];
  logic [REM_W-1:0]  s_rem_d  [ROOT_W+1];
  logic [ROOT_W-1:0] s_root_d [ROOT_W+1];

  // classify stage
  logic             c_vld_q;
  cls_e             c_cls_q, c_cls_d;
  logic [NUM_W-1:0] c_num_q, c_num_d;

  // divide stages
  logic              d_vld_q [Q_BITS];
  cls_e              d_cls_q [Q_BITS];
  logic [NUM_W-1:0]  d_num_q [Q_BITS];
  logic [Q_BITS-1:0] d_quo_q [Q_BITS];
  logic [NUM_W-1:0]  d_num_d [Q_BITS];
  logic [Q_BITS-1:0] d_quo_d [Q_BITS];

  logic       out_vld_q;
  logic [7:0] out_q, out_d;

  logic             en;
  logic [DIM_W-1:0] mn;
  logic [M_W-1:0]   m;
  logic [D5_W-1:0]  d5, lo, hi, diff;
  logic [M_W-1:0]   diff_m;
  logic [NUM_W-1:0] m_ext, fin_num;
  logic [Q_BITS-1:0] fin_quo;
  logic [REM_W-1:0] rem_sh, trial;

  assign en    = !(out_vld_q && alpha_stall_i);
  assign pop_o = en && !fifo_stat_i.empty;

  assign mn    = (width_i < height_i) ? width_i : height_i;
  assign m     = M_W'(mn) << DIST_FRAC_BITS;
  assign m_ext = NUM_W'(m);

  // one root bit per stage
  always_comb begin
    s_v_d[0]    = {pop_sq_i, {(2*DIST_FRAC_BITS){1'b0}}};
    s_rem_d[0]  = '0;
    s_root_d[0] = '0;
    rem_sh      = '0;
    trial       = '0;
    for (int k = 0; k < ROOT_W; k++) begin
      rem_sh = {s_rem_q[k][REM_W-3:0], s_v_q[k][V_W-1 -: 2]};
      trial  = REM_W'({s_root_q[k], 2'b01});
      s_v_d[k+1] = s_v_q[k] << 2;
      if (rem_sh >= trial) begin
        s_rem_d[k+1]  = rem_sh - trial;
        s_root_d[k+1] = {s_root_q[k][ROOT_W-2:0], 1'b1};
      end else begin
        s_rem_d[k+1]  = rem_sh;
        s_root_d[k+1] = {s_root_q[k][ROOT_W-2:0], 1'b0};
      end
    end
  end

  // exact edge tests: 5D against 3m and 4m
  always_comb begin
    d5     = D5_W'(s_root_q[ROOT_W]) + (D5_W'(s_root_q[ROOT_W]) << 2);
    lo     = D5_W'(m) + (D5_W'(m) << 1);
    hi     = D5_W'(m) << 2;
    diff   = d5 - lo;
    diff_m = diff[M_W-1:0];
    c_num_d = (NUM_W'(diff_m) << 8) - NUM_W'(diff_m);
    if (d5 < lo)      c_cls_d = CLS_ZERO;
    else if (d5 > hi) c_cls_d = CLS_FULL;
    else              c_cls_d = CLS_RAMP;
  end

  // restoring divide, quotient MSB first
  always_comb begin
    d_num_d[0] = c_num_q;
    d_quo_d[0] = '0;
    for (int j = 0; j < Q_BITS - 1; j++) begin
      d_num_d[j+1] = d_num_q[j];
      d_quo_d[j+1] = d_quo_q[j];
      if (d_num_q[j] >= (m_ext << (Q_BITS - 1 - j))) begin
        d_num_d[j+1]                 = d_num_q[j] - (m_ext << (Q_BITS - 1 - j));
        d_quo_d[j+1][Q_BITS - 1 - j] = 1'b1;
      end
    end
    fin_num = d_num_q[Q_BITS-1];
    fin_quo = d_quo_q[Q_BITS-1];
    if (fin_num >= m_ext) fin_quo[0] = 1'b1;
    unique case (d_cls_q[Q_BITS-1])
      CLS_ZERO: out_d = 8'd0;
      CLS_FULL: out_d = 8'd255;
      CLS_RAMP: out_d = fin_quo;
      default:  out_d = 8'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= ROOT_W; k++) s_vld_q[k] <= 1'b0;
      for (int j = 0; j < Q_BITS; j++)  d_vld_q[j] <= 1'b0;
      c_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      s_vld_q[0] <= pop_o;
      for (int k = 0; k < ROOT_W; k++) s_vld_q[k+1] <= s_vld_q[k];
      c_vld_q    <= s_vld_q[ROOT_W];
      d_vld_q[0] <= c_vld_q;
      for (int j = 0; j < Q_BITS - 1; j++) d_vld_q[j+1] <= d_vld_q[j];
      out_vld_q  <= d_vld_q[Q_BITS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k <= ROOT_W; k++) begin
        s_v_q[k]    <= s_v_d[k];
        s_rem_q[k]  <= s_rem_d[k];
        s_root_q[k] <= s_root_d[k];
      end
      c_cls_q    <= c_cls_d;
      c_num_q    <= c_num_d;
      d_cls_q[0] <= c_cls_q;
      for (int j = 0; j < Q_BITS; j++) begin
        d_num_q[j] <= d_num_d[j];
        d_quo_q[j] <= d_quo_d[j];
      end
      for (int j = 0; j < Q_BITS - 1; j++) d_cls_q[j+1] <= d_cls_q[j];
      out_q <= out_d;
    end
  end

  assign alpha_valid_o = out_vld_q;
  assign alpha_o       = out_q;

endmodule

[hw/rtl/radial_vignette_alpha.sv]
// Path from the edge that accepts the pixel request to alpha: offset stage, queue,
// 23 root stages, classify, 8 divide stages, output reg.
// Throughput: one pixel per cycle while alpha_stall_i is low; the root and divide units are fully pipelined.
// Reset: asynchronous, active low; frame size returns to 1024 x 768, queue and
// pipeline empty.
// ----------------------------------------------------------------------------
// radial_vignette_alpha
// Radial vignette overlay alpha from a pixel coordinate.
// ----------------------------------------------------------------------------
module radial_vignette_alpha (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [1:0]                  cfg_index_i,
  input  logic [rva_pkg::DIM_W-1:0]   cfg_data_i,
  input  logic                        pixel_valid_i,
  output logic                        pixel_stall_o,
  input  logic [rva_pkg::PIX_W-1:0]   pixel_x_i,
  input  logic [rva_pkg::PIX_W-1:0]   pixel_y_i,
  output logic                        alpha_valid_o,
  input  logic                        alpha_stall_i,
  output logic [7:0]                  alpha_o
);
  import rva_pkg::*;

  logic [DIM_W-1:0] fw_q, fw_d, fh_q, fh_d, w, h;
  fifo_stat_t       fstat;
  logic             push, pop;
  logic [SQ_W-1:0]  push_sq, pop_sq;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    fw_d = fw_q;
    fh_d = fh_q;
    if (cfg_valid_i) begin
      if (cfg_index_i == REG_FRAME_WIDTH)  fw_d = cfg_data_i;
      if (cfg_index_i == REG_FRAME_HEIGHT) fh_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= DIM_W'(1024);
      fh_q <= DIM_W'(768);
    end else begin
      fw_q <= fw_d;
      fh_q <= fh_d;
    end
  end

  assign w = clamp_dim(fw_q);
  assign h = clamp_dim(fh_q);

  rva_front u_front (
    .clk_i, .rst_ni, .pixel_valid_i, .pixel_stall_o, .pixel_x_i, .pixel_y_i,
    .width_i(w), .height_i(h), .fifo_stat_i(fstat), .push_o(push), .push_sq_o(push_sq)
  );

  rva_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .push_sq_i(push_sq), .pop_i(pop),
    .pop_sq_o(pop_sq), .stat_o(fstat)
  );

  rva_back u_back (
    .clk_i, .rst_ni, .fifo_stat_i(fstat), .pop_sq_i(pop_sq), .pop_o(pop),
    .width_i(w), .height_i(h), .alpha_valid_o, .alpha_stall_i, .alpha_o
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (fstat.count < FIFO_CW'(FIFO_DEPTH)))
    else $error("queue push while full");

  a_accept_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pixel_valid_i && !pixel_stall_o) |=> push)
    else $error("accepted pixel not queued");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !fstat.empty)
    else $error("queue pop while empty");

endmodule
